@@ rtl/tms_pkg.sv @@
// tms_pkg: shared types, codes and defaults of the turing machine stepper
// used by the channel interfaces and every module of the block but tms_ram
package tms_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int TAPE_CELLS_DEF  = 128;
  localparam int HOME_POS_DEF    = 39;

  localparam logic [7:0] BLANK_SYM = 8'h5F;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;
  localparam logic [1:0] FUNC_STEP   = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_STEPPED  = 3'd1;
  localparam logic [2:0] ST_HALTED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_OFF_TAPE = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cur_state;
    logic [7:0] read_sym;
    logic [7:0] write_sym;
    logic       move_left;
    logic [7:0] next_state;
    logic [6:0] tape_pos;
    logic [7:0] tape_sym;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] state_now;
    logic [6:0] head_pos;
    logic [7:0] head_symbol;
  } res_t;

  // one transition table entry, 33 bits
  typedef struct packed {
    logic [7:0] cur_state;
    logic [7:0] read_sym;
    logic [7:0] write_sym;
    logic       move_left;
    logic [7:0] next_state;
  } rule_t;

  typedef struct packed {
    logic hit;
    logic off_tape;
  } match_res_t;

endpackage

@@ rtl/tms_if.sv @@
// tms_cmd_if, tms_res_if: valid/ready channels of the stepper
// depends on tms_pkg for the payload types
interface tms_cmd_if;
  import tms_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tms_res_if;
  import tms_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tms_ram.sv @@
// tms_ram: generic single write port, single read port ram
// registered read data, no reset of contents; no package dependency
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tms_match.sv @@
// tms_match: compare unit shared by every table entry during a scan
// checks state and symbol, works out the head move; depends on tms_pkg
module tms_match #(
  parameter int TAPE_CELLS = 128,
  parameter int HW         = $clog2(TAPE_CELLS)
) (
  input  tms_pkg::rule_t     rule,
  input  logic [7:0]         state,
  input  logic [7:0]         sym,
  input  logic [HW-1:0]      head,
  output tms_pkg::match_res_t res,
  output logic [HW-1:0]      head_next
);
  import tms_pkg::*;

  always_comb begin
    res.hit      = (rule.cur_state == state) && (rule.read_sym == sym);
    res.off_tape = rule.move_left ? (head == '0) : (head == HW'(TAPE_CELLS - 1));
    head_next    = rule.move_left ? (head - HW'(1)) : (head + HW'(1));
  end

endmodule

@@ rtl/turing_machine_stepper.sv @@
// turing_machine_stepper: top level, sequencer and state of the machine
// depends on tms_pkg, tms_if, tms_ram and tms_match

// Single-tape Turing machine engine. Each cmd transaction appends a rule, writes a
// tape cell, starts a run or does one step, and gives exactly one res transaction.
// Append, tape write, empty start and a halted step go through the head read and
// emit states; a start goes through S_START first. A step runs S_STEP, then the
// scan, which ends at the first matching rule or after the last entry: the
// rule ram delivers one entry per cycle to the single compare unit. cmd is not
// ready while an item is in work. After reset a clearing pass writes blanks
// into the tape ram, one cell per cycle, before the first command is taken.
module turing_machine_stepper #(
  parameter int TABLE_DEPTH = tms_pkg::TABLE_DEPTH_DEF,
  parameter int TAPE_CELLS  = tms_pkg::TAPE_CELLS_DEF,
  parameter int HOME_POS    = tms_pkg::HOME_POS_DEF
) (
  input logic      clk,
  input logic      rst,
  tms_cmd_if.sink  cmd,
  tms_res_if.source res
);
  import tms_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int HW  = $clog2(TAPE_CELLS);
  localparam int XW  = (HW > 7) ? HW : 7;
  localparam int HMW = ((HW > 9) ? HW : 9) + 1;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_START   = 3'd2;
  localparam logic [2:0] S_STEP    = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_HEAD_RD = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0]    state;
  logic [HW-1:0] clr_idx;
  logic [CW-1:0] rule_count;
  logic [CW-1:0] idx;
  logic          pend;
  logic [7:0]    machine_state;
  logic [HW-1:0] head;
  logic          running;
  logic [2:0]    status;

  logic          res_valid;
  res_t          res_data;

  logic          acc;
  logic          full;
  logic [XW-1:0] pos_ext;
  logic [XW-1:0] head_ext;
  logic          pos_ok;
  logic [HMW-1:0] home;

  logic          rule_we, rule_re;
  logic [AW-1:0] rule_raddr;
  rule_t         rule_wdata, rule_rd;
  logic          tape_we, tape_re;
  logic [HW-1:0] tape_waddr;
  logic [7:0]    tape_wdata, tape_rd;

  match_res_t    mres;
  logic [HW-1:0] head_next;
  logic          issue;

  assign cmd.ready = (state == S_IDLE);
  assign acc       = cmd.valid && cmd.ready;
  assign full      = (rule_count == CW'(TABLE_DEPTH));
  assign pos_ext   = XW'(cmd.data.tape_pos);
  assign pos_ok    = ({1'b0, pos_ext} < (XW + 1)'(TAPE_CELLS));
  assign head_ext  = XW'(head);
  assign home      = HMW'(HOME_POS) + HMW'(rule_rd.cur_state);
  assign issue     = (state == S_SCAN) && !(pend && mres.hit) && (idx != rule_count);

  assign res.valid = res_valid;
  assign res.data  = res_data;

  always_comb begin
    rule_we    = acc && (cmd.data.func == FUNC_APPEND) && !full;
    rule_wdata = '{cur_state:  cmd.data.cur_state,
                   read_sym:   cmd.data.read_sym,
                   write_sym:  cmd.data.write_sym,
                   move_left:  cmd.data.move_left,
                   next_state: cmd.data.next_state};
    rule_re    = (acc && (cmd.data.func == FUNC_START)) || issue;
    rule_raddr = (state == S_SCAN) ? idx[AW-1:0] : '0;

    tape_we    = 1'b0;
    tape_waddr = head;
    tape_wdata = rule_rd.write_sym;
    if (state == S_CLEAR) begin
      tape_we    = 1'b1;
      tape_waddr = clr_idx;
      tape_wdata = BLANK_SYM;
    end else if (acc && (cmd.data.func == FUNC_WRITE) && pos_ok) begin
      tape_we    = 1'b1;
      tape_waddr = pos_ext[HW-1:0];
      tape_wdata = cmd.data.tape_sym;
    end else if ((state == S_SCAN) && pend && mres.hit) begin
      tape_we    = 1'b1;
    end
    tape_re = (state == S_STEP) || (state == S_HEAD_RD);
  end

  tms_ram #(.WIDTH($bits(rule_t)), .DEPTH(TABLE_DEPTH), .AW(AW)) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_count[AW-1:0]),
    .wdata (rule_wdata),
    .re    (rule_re),
    .raddr (rule_raddr),
    .rdata (rule_rd)
  );

  tms_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS), .AW(HW)) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (tape_re),
    .raddr (head),
    .rdata (tape_rd)
  );

  // symbol under the head stays on the tape read port during the scan
  tms_match #(.TAPE_CELLS(TAPE_CELLS), .HW(HW)) u_match (
    .rule      (rule_rd),
    .state     (machine_state),
    .sym       (tape_rd),
    .head      (head),
    .res       (mres),
    .head_next (head_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      rule_count    <= '0;
      idx           <= '0;
      pend          <= 1'b0;
      machine_state <= '0;
      head          <= '0;
      running       <= 1'b0;
      status        <= ST_ACCEPTED;
      res_valid     <= 1'b0;
    end else begin
      // the emit state reloads the result slot itself
      if (res_valid && res.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + HW'(1);
          if (clr_idx == HW'(TAPE_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            unique case (cmd.data.func)
              FUNC_APPEND: begin
                status <= full ? ST_FULL : ST_ACCEPTED;
                state  <= S_HEAD_RD;
                if (!full) begin
                  rule_count <= rule_count + CW'(1);
                end
              end
              FUNC_WRITE: begin
                status <= pos_ok ? ST_ACCEPTED : ST_OFF_TAPE;
                state  <= S_HEAD_RD;
              end
              FUNC_START: begin
                if (rule_count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_HEAD_RD;
                end else begin
                  state <= S_START;
                end
              end
              FUNC_STEP: begin
                if (!running) begin
                  status <= ST_HALTED;
                  state  <= S_HEAD_RD;
                end else begin
                  state <= S_STEP;
                end
              end
              default: state <= S_HEAD_RD;
            endcase
          end
        end
        S_START: begin
          machine_state <= rule_rd.cur_state;
          state         <= S_HEAD_RD;
          if (home >= HMW'(TAPE_CELLS)) begin
            running <= 1'b0;
            status  <= ST_OFF_TAPE;
          end else begin
            head    <= home[HW-1:0];
            running <= 1'b1;
            status  <= ST_ACCEPTED;
          end
        end
        S_STEP: begin
          idx   <= '0;
          pend  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // compare the entry fetched last cycle while fetching the next one
          if (pend && mres.hit) begin
            machine_state <= rule_rd.next_state;
            state         <= S_HEAD_RD;
            if (mres.off_tape) begin
              running <= 1'b0;
              status  <= ST_OFF_TAPE;
            end else begin
              head   <= head_next;
              status <= ST_STEPPED;
            end
          end else if (idx == rule_count) begin
            running <= 1'b0;
            status  <= ST_HALTED;
            state   <= S_HEAD_RD;
          end else begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end
        end
        S_HEAD_RD: state <= S_EMIT;
        S_EMIT: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!res_valid || res.ready)) begin
      res_data.status      <= status;
      res_data.state_now   <= machine_state;
      res_data.head_pos    <= head_ext[6:0];
      res_data.head_symbol <= tape_rd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CW'(TABLE_DEPTH))
    else $error("rule count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("new command taken while one is in work");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && (cmd.data.func == FUNC_APPEND) && !full
    |=> rule_count == $past(rule_count) + CW'(1))
    else $error("append did not grow the table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> idx <= rule_count)
    else $error("scan index past table end");

endmodule
